// ===== design/u8_s8_dot_product_accumulator_core_defines.svh =====
// Shared assertion macros for the dot-product accumulator.
// Each expects clk and arst_n in scope.
`ifndef U8_S8_DOT_PRODUCT_ACCUMULATOR_CORE_DEFINES_SVH
`define U8_S8_DOT_PRODUCT_ACCUMULATOR_CORE_DEFINES_SVH

// same-cycle implication
`define DPA_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define DPA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/dpa_pkg.sv =====
package dpa_pkg;

	localparam int LANE_COUNT   = 8;
	localparam int BYTES_LANE   = 4;
	localparam int ACC_W        = 32;
	// |4 * 255 * -128| fits in 18 signed bits; keep one spare
	localparam int DOT_W        = 19;
	localparam int DOT_SUM_W    = DOT_W + 3;
	localparam int QUEUE_DEPTH  = 4;

	localparam logic [1:0] CMD_CLEAR_ADD = 2'd0;
	localparam logic [1:0] CMD_ADD       = 2'd1;
	localparam logic [1:0] CMD_PRESET    = 2'd2;

	typedef enum logic [1:0] {
		OP_CLEAR_ADD,
		OP_ADD,
		OP_PRESET,
		OP_HOLD
	} op_t;

	typedef logic signed [DOT_W-1:0] dot_t;

	typedef struct packed {
		op_t                          op;
		dot_t [LANE_COUNT-1:0]        dot;
		logic signed [DOT_SUM_W-1:0]  dot_sum;
		logic [2:0]                   lane_index;
		logic signed [ACC_W-1:0]      lane_value;
	} entry_t;

endpackage

// ===== design/dpa_in_if.sv =====
interface dpa_in_if;
	logic               valid;
	logic               ready;
	logic [1:0]         command;
	logic [63:0]        a_word0;
	logic [63:0]        a_word1;
	logic [63:0]        a_word2;
	logic [63:0]        a_word3;
	logic [63:0]        b_word0;
	logic [63:0]        b_word1;
	logic [63:0]        b_word2;
	logic [63:0]        b_word3;
	logic [2:0]         lane_index;
	logic signed [31:0] lane_value;

	modport source (
		output valid, command, a_word0, a_word1, a_word2, a_word3,
		       b_word0, b_word1, b_word2, b_word3, lane_index, lane_value,
		input  ready
	);
	modport sink (
		input  valid, command, a_word0, a_word1, a_word2, a_word3,
		       b_word0, b_word1, b_word2, b_word3, lane_index, lane_value,
		output ready
	);
endinterface

// ===== design/dpa_out_if.sv =====
interface dpa_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] lane0;
	logic signed [31:0] lane1;
	logic signed [31:0] lane2;
	logic signed [31:0] lane3;
	logic signed [31:0] lane4;
	logic signed [31:0] lane5;
	logic signed [31:0] lane6;
	logic signed [31:0] lane7;
	logic signed [31:0] total;

	modport source (
		output valid, lane0, lane1, lane2, lane3, lane4, lane5, lane6, lane7, total,
		input  ready
	);
	modport sink (
		input  valid, lane0, lane1, lane2, lane3, lane4, lane5, lane6, lane7, total,
		output ready
	);
endinterface

// ===== design/dpa_front.sv =====
module dpa_front import dpa_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	dpa_in_if.sink req,
	output entry_t push_data,
	output logic   push,
	input  logic   full
);

	logic                          en;
	logic [8*LANE_COUNT*BYTES_LANE-1:0] a_all;
	logic [8*LANE_COUNT*BYTES_LANE-1:0] b_all;
	dot_t [LANE_COUNT-1:0]         dot_c;
	op_t                           op_c;

	logic                          v_s1;
	entry_t                        ent_s1;
	logic                          v_s2;
	entry_t                        ent_s2;

	// whole front advances together; stall only when the queue refuses the tail
	assign en        = !v_s2 || !full;
	assign req.ready = en;
	assign push      = v_s2 && !full;
	assign push_data = ent_s2;

	assign a_all = {req.a_word3, req.a_word2, req.a_word1, req.a_word0};
	assign b_all = {req.b_word3, req.b_word2, req.b_word1, req.b_word0};

	always_comb begin
		logic signed [16:0]    prod;
		logic signed [DOT_W-1:0] acc;
		for (int l = 0; l < LANE_COUNT; l++) begin
			acc = '0;
			for (int k = 0; k < BYTES_LANE; k++) begin
				prod = $signed({1'b0, a_all[8*(BYTES_LANE*l+k) +: 8]})
				     * $signed(b_all[8*(BYTES_LANE*l+k) +: 8]);
				acc  = acc + DOT_W'(prod);
			end
			dot_c[l] = acc;
		end
	end

	always_comb begin
		case (req.command)
			CMD_CLEAR_ADD: op_c = OP_CLEAR_ADD;
			CMD_ADD:       op_c = OP_ADD;
			CMD_PRESET:    op_c = OP_PRESET;
			default:       op_c = OP_HOLD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= req.valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ent_s1.op         <= op_c;
			ent_s1.dot        <= dot_c;
			ent_s1.dot_sum    <= '0;
			ent_s1.lane_index <= req.lane_index;
			ent_s1.lane_value <= req.lane_value;
		end
	end

	// horizontal sum of the eight lane products, one stage later
	always_ff @(posedge clk) begin
		logic signed [DOT_SUM_W-1:0] s;
		entry_t                      nxt;
		if (en) begin
			s = '0;
			for (int l = 0; l < LANE_COUNT; l++)
				s = s + DOT_SUM_W'($signed(ent_s1.dot[l]));
			nxt         = ent_s1;
			nxt.dot_sum = s;
			ent_s2      <= nxt;
		end
	end

endmodule

// ===== design/dpa_queue.sv =====
`include "u8_s8_dot_product_accumulator_core_defines.svh"

module dpa_queue import dpa_pkg::*; #(
	parameter int Depth = QUEUE_DEPTH
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t push_data,
	output logic   full,
	input  logic   pop,
	output entry_t pop_data,
	output logic   empty
);

	// Depth must be a power of two so the pointers wrap on their own
	localparam int PtrW = $clog2(Depth);
	localparam int CntW = $clog2(Depth + 1);

	entry_t              mem_q [Depth];
	logic [PtrW-1:0]     wr_ptr_q;
	logic [PtrW-1:0]     rd_ptr_q;
	logic [CntW-1:0]     count_q;

	assign full     = count_q == CntW'(Depth);
	assign empty    = count_q == '0;
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_data;
	end

	`DPA_ASSERT_NOW(a_q_no_overfill, push, !full, "beat pushed into a full queue")
	`DPA_ASSERT_NOW(a_q_no_underrun, pop, !empty, "beat popped from an empty queue")
	`DPA_ASSERT_NEXT(a_q_fill_tracks, push && !pop, count_q == $past(count_q) + 1'b1,
		"queue fill count did not advance on push")

endmodule

// ===== design/dpa_back.sv =====
`include "u8_s8_dot_product_accumulator_core_defines.svh"

module dpa_back import dpa_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  entry_t     pop_data,
	input  logic       empty,
	output logic       pop,
	dpa_out_if.source  rsp
);

	logic [LANE_COUNT-1:0][ACC_W-1:0] lane_acc_q;
	logic [ACC_W-1:0]                 total_q;
	logic                             out_valid_q;
	logic [LANE_COUNT-1:0][ACC_W-1:0] lane_nxt;
	logic [ACC_W-1:0]                 total_nxt;
	logic [ACC_W-1:0]                 lane_sum_chk;

	// the lane registers are the result register; refill only once the old beat is gone
	assign pop = !empty && (!out_valid_q || rsp.ready);

	always_comb begin
		lane_nxt  = lane_acc_q;
		total_nxt = total_q;
		case (pop_data.op)
			OP_CLEAR_ADD: begin
				for (int l = 0; l < LANE_COUNT; l++)
					lane_nxt[l] = ACC_W'($signed(pop_data.dot[l]));
				total_nxt = ACC_W'($signed(pop_data.dot_sum));
			end
			OP_ADD: begin
				for (int l = 0; l < LANE_COUNT; l++)
					lane_nxt[l] = lane_acc_q[l] + ACC_W'($signed(pop_data.dot[l]));
				total_nxt = total_q + ACC_W'($signed(pop_data.dot_sum));
			end
			OP_PRESET: begin
				lane_nxt[pop_data.lane_index] = pop_data.lane_value;
				total_nxt = total_q - lane_acc_q[pop_data.lane_index]
				          + pop_data.lane_value;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lane_acc_q  <= '0;
			total_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				lane_acc_q  <= lane_nxt;
				total_q     <= total_nxt;
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.lane0 = lane_acc_q[0];
	assign rsp.lane1 = lane_acc_q[1];
	assign rsp.lane2 = lane_acc_q[2];
	assign rsp.lane3 = lane_acc_q[3];
	assign rsp.lane4 = lane_acc_q[4];
	assign rsp.lane5 = lane_acc_q[5];
	assign rsp.lane6 = lane_acc_q[6];
	assign rsp.lane7 = lane_acc_q[7];
	assign rsp.total = total_q;

	always_comb begin
		lane_sum_chk = '0;
		for (int l = 0; l < LANE_COUNT; l++)
			lane_sum_chk = lane_sum_chk + lane_acc_q[l];
	end

	`DPA_ASSERT_NOW(a_total_matches, 1'b1, total_q == lane_sum_chk,
		"running total drifted from the lane sum")
	`DPA_ASSERT_NEXT(a_lanes_hold, rsp.valid && !rsp.ready, $stable(lane_acc_q) && rsp.valid,
		"lanes changed under a stalled beat")
	`DPA_ASSERT_NEXT(a_pop_presents, pop, rsp.valid,
		"popped beat not presented on the result channel")

endmodule

// ===== design/u8_s8_dot_product_accumulator_core.sv =====
// Unsigned-by-signed byte dot-product accumulator, eight 32-bit lanes.
// req carries one beat per 32-byte block pair: a command, four words of
// unsigned bytes, four words of signed bytes, and a lane index and value
// for preset. Clear-and-add and add fold four byte products per lane into
// the lane accumulators; preset loads one lane; any other command leaves
// the lanes as they are. rsp returns one beat per request with all eight
// lanes and their wrapping 32-bit total.
// A result passes through two front stages for the products and their sum,
// one queue slot, then the lane update. Throughput: one beat per cycle
// while rsp.ready stays high, set by the single accumulate stage which
// closes its loop on its own lane registers.
// Reset clears every lane and the total to zero and empties the pipeline.
// When the receiver stalls, the result holds; the queue between front and
// back keeps absorbing requests until it is full and a beat waits at the front's tail, then req.ready drops.
module u8_s8_dot_product_accumulator_core import dpa_pkg::*; #(
	parameter int QueueDepth = QUEUE_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	dpa_in_if.sink    req,
	dpa_out_if.source rsp
);

	entry_t push_data;
	entry_t pop_data;
	logic   push;
	logic   pop;
	logic   full;
	logic   empty;

	dpa_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.push_data (push_data),
		.push      (push),
		.full      (full)
	);

	dpa_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.pop_data  (pop_data),
		.empty     (empty)
	);

	dpa_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.pop_data (pop_data),
		.empty    (empty),
		.pop      (pop),
		.rsp      (rsp)
	);

endmodule

// ===== dv/dpa_checker.sv =====
module dpa_checker import dpa_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	dpa_in_if    req,
	dpa_out_if   rsp,
	output int   mismatches,
	output int   due_count,
	output int   results_checked
);

	typedef struct packed {
		logic [LANE_COUNT-1:0][ACC_W-1:0] lanes;
		logic [ACC_W-1:0]                 total;
	} lane_report_t;

	logic [ACC_W-1:0] lane_acc_model [LANE_COUNT];
	lane_report_t     reports_due[$];

	// four unsigned-by-signed byte products, summed
	function automatic logic [ACC_W-1:0] byte_dot(input logic [31:0] ua, input logic [31:0] sb);
		int sum;
		sum = 0;
		for (int k = 0; k < BYTES_LANE; k++)
			sum += int'(ua[8*k +: 8]) * int'($signed(sb[8*k +: 8]));
		return sum;
	endfunction

	function automatic lane_report_t accumulate_beat();
		logic [3:0][63:0] a_words;
		logic [3:0][63:0] b_words;
		lane_report_t     report;
		op_t              op;
		a_words = {req.a_word3, req.a_word2, req.a_word1, req.a_word0};
		b_words = {req.b_word3, req.b_word2, req.b_word1, req.b_word0};
		op = op_t'(req.command);
		case (op)
			OP_CLEAR_ADD, OP_ADD: begin
				for (int i = 0; i < LANE_COUNT; i++) begin
					lane_acc_model[i] = ((op == OP_CLEAR_ADD) ? '0 : lane_acc_model[i])
						+ byte_dot(a_words[i/2][32*(i%2) +: 32], b_words[i/2][32*(i%2) +: 32]);
				end
			end
			OP_PRESET: lane_acc_model[req.lane_index] = req.lane_value;
			default: ;
		endcase
		report.total = '0;
		for (int i = 0; i < LANE_COUNT; i++) begin
			report.lanes[i] = lane_acc_model[i];
			report.total += lane_acc_model[i];
		end
		return report;
	endfunction

	task automatic compare_report();
		lane_report_t want;
		lane_report_t seen;
		seen.lanes = {rsp.lane7, rsp.lane6, rsp.lane5, rsp.lane4,
		              rsp.lane3, rsp.lane2, rsp.lane1, rsp.lane0};
		seen.total = rsp.total;
		results_checked++;
		if (reports_due.size() == 0) begin
			$display("%0t: result beat with nothing due, expected none got lanes %h total %h",
				$time, seen.lanes, seen.total);
			mismatches++;
		end else begin
			want = reports_due.pop_front();
			for (int i = 0; i < LANE_COUNT; i++) begin
				if (want.lanes[i] !== seen.lanes[i]) begin
					$display("%0t: lane%0d expected %h got %h", $time, i,
						want.lanes[i], seen.lanes[i]);
					mismatches++;
				end
			end
			if (want.total !== seen.total) begin
				$display("%0t: total expected %h got %h", $time, want.total, seen.total);
				mismatches++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (lane_acc_model[i])
				lane_acc_model[i] = '0;
			reports_due.delete();
			mismatches      = 0;
			results_checked = 0;
			due_count       = 0;
		end else begin
			if (req.valid && req.ready)
				reports_due.push_back(accumulate_beat());
			if (rsp.valid && rsp.ready)
				compare_report();
			due_count = reports_due.size();
		end
	end

endmodule

// ===== dv/testbench.sv =====
module testbench;
	import dpa_pkg::*;

	typedef struct packed {
		op_t              command;
		logic [3:0][63:0] a;
		logic [3:0][63:0] b;
		logic [2:0]       lane_index;
		logic [31:0]      lane_value;
	} beat_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	bit   steady = 1'b0;
	int   beats_sent = 0;
	int   per_op[4] = '{0, 0, 0, 0};
	int   mismatches;
	int   due_count;
	int   results_checked;

	dpa_in_if  req_ch();
	dpa_out_if rsp_ch();

	u8_s8_dot_product_accumulator_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	dpa_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.req             (req_ch),
		.rsp             (rsp_ch),
		.mismatches      (mismatches),
		.due_count       (due_count),
		.results_checked (results_checked)
	);

	always #5 clk = ~clk;

	initial rsp_ch.ready = 1'b0;
	always @(posedge clk) begin
		rsp_ch.ready <= steady || ($urandom_range(99) >= 25);
	end

	function automatic logic [7:0] edge_byte();
		case ($urandom_range(5))
			0: return 8'h00;
			1: return 8'h01;
			2: return 8'h7f;
			3: return 8'h80;
			4: return 8'hff;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic logic [63:0] random_word();
		logic [63:0] w;
		case ($urandom_range(3))
			0, 1: w = {$urandom, $urandom};
			2: for (int k = 0; k < 8; k++) w[8*k +: 8] = edge_byte();
			default: w = {8{edge_byte()}};
		endcase
		return w;
	endfunction

	// bias presets towards the wrap points so later adds cross them
	function automatic logic [31:0] random_lane_value();
		case ($urandom_range(3))
			0: return 32'h7fff_ffff - $urandom_range(300000);
			1: return 32'h8000_0000 + $urandom_range(300000);
			default: return $urandom;
		endcase
	endfunction

	function automatic beat_t random_block(input op_t op);
		beat_t bt;
		bt.command = op;
		for (int w = 0; w < 4; w++) begin
			bt.a[w] = random_word();
			bt.b[w] = random_word();
		end
		bt.lane_index = 3'($urandom);
		bt.lane_value = random_lane_value();
		return bt;
	endfunction

	function automatic beat_t flat_block(input op_t op, input logic [7:0] av,
			input logic [7:0] bv);
		beat_t bt;
		bt = random_block(op);
		bt.a = {32{av}};
		bt.b = {32{bv}};
		return bt;
	endfunction

	function automatic beat_t preset_beat(input logic [2:0] idx, input logic [31:0] val);
		beat_t bt;
		bt = random_block(OP_PRESET);
		bt.lane_index = idx;
		bt.lane_value = val;
		return bt;
	endfunction

	task automatic drive_beat(input beat_t bt);
		while (!steady && $urandom_range(99) < 25) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid      <= 1'b1;
		req_ch.command    <= bt.command;
		req_ch.a_word0    <= bt.a[0];
		req_ch.a_word1    <= bt.a[1];
		req_ch.a_word2    <= bt.a[2];
		req_ch.a_word3    <= bt.a[3];
		req_ch.b_word0    <= bt.b[0];
		req_ch.b_word1    <= bt.b[1];
		req_ch.b_word2    <= bt.b[2];
		req_ch.b_word3    <= bt.b[3];
		req_ch.lane_index <= bt.lane_index;
		req_ch.lane_value <= bt.lane_value;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		beats_sent++;
		per_op[bt.command]++;
	endtask

	initial begin
		int run_len;
		req_ch.valid      <= 1'b0;
		req_ch.command    <= OP_HOLD;
		req_ch.a_word0    <= '0;
		req_ch.a_word1    <= '0;
		req_ch.a_word2    <= '0;
		req_ch.a_word3    <= '0;
		req_ch.b_word0    <= '0;
		req_ch.b_word1    <= '0;
		req_ch.b_word2    <= '0;
		req_ch.b_word3    <= '0;
		req_ch.lane_index <= '0;
		req_ch.lane_value <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		drive_beat(flat_block(OP_CLEAR_ADD, 8'h00, 8'h00));
		drive_beat(flat_block(OP_CLEAR_ADD, 8'hff, 8'h80));
		drive_beat(flat_block(OP_ADD, 8'hff, 8'h80));
		drive_beat(flat_block(OP_CLEAR_ADD, 8'hff, 8'h7f));
		drive_beat(flat_block(OP_ADD, 8'h00, 8'hff));
		drive_beat(flat_block(OP_ADD, 8'h01, 8'hff));
		drive_beat(flat_block(OP_ADD, 8'h80, 8'h01));
		// push lane 0 over the positive limit and lane 7 under the negative one
		drive_beat(preset_beat(3'd0, 32'h7fff_ffff));
		drive_beat(flat_block(OP_ADD, 8'hff, 8'h7f));
		drive_beat(preset_beat(3'd7, 32'h8000_0000));
		drive_beat(flat_block(OP_ADD, 8'hff, 8'h80));
		for (int i = 1; i < 7; i++)
			drive_beat(preset_beat(3'(i), 32'h7fff_ffff));
		drive_beat(random_block(OP_HOLD));
		drive_beat(flat_block(OP_HOLD, 8'hff, 8'h80));
		drive_beat(random_block(OP_CLEAR_ADD));
		drive_beat(preset_beat(3'd3, 32'h0000_0000));
		drive_beat(random_block(OP_ADD));

		// mostly clear-or-preset then a run of adds; some loose beats for noise
		while (beats_sent < 1472) begin
			steady = (beats_sent >= 520 && beats_sent < 820);
			if ($urandom_range(99) < 85) begin
				drive_beat(random_block(($urandom_range(3) == 0) ? OP_PRESET : OP_CLEAR_ADD));
				run_len = $urandom_range(2, 12);
				for (int j = 0; j < run_len; j++)
					drive_beat(random_block(($urandom_range(9) == 0) ? OP_PRESET : OP_ADD));
			end else begin
				drive_beat(random_block(op_t'($urandom_range(3))));
			end
		end
		req_ch.valid <= 1'b0;

		while (due_count != 0) @(negedge clk);
		repeat (8) @(posedge clk);

		$display("%0d beats sent: %0d clear-add, %0d add, %0d preset, %0d hold",
			beats_sent, per_op[OP_CLEAR_ADD], per_op[OP_ADD], per_op[OP_PRESET],
			per_op[OP_HOLD]);
		$display("%0d result beats compared, byte extremes and lane wrap included",
			results_checked);
		if (mismatches == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("timeout with %0d results still due", due_count);
		$display("== FAIL ==");
		$finish;
	end

endmodule
